>>> rtl/base64_stream_codec_unit_defines.svh
// Assertion macros used by the checker of the base64 stream codec.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef BASE64_STREAM_CODEC_UNIT_DEFINES_SVH
`define BASE64_STREAM_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64C_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/b64c_pkg.sv
// Package for the base64 stream codec: job record, character constants and
// the alphabet mapping functions. Depends on nothing.
package b64c_pkg;

    // Default depth of the job queue between front and back.
    localparam int JOB_DEPTH = 2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
    localparam logic [7:0] CHAR_UPPER = 8'h41; // 'A'
    localparam logic [7:0] CHAR_LOWER = 8'h61; // 'a'
    localparam logic [7:0] CHAR_DIGIT = 8'h30; // '0'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'

    // One group of work for the back end. The group bits are already
    // zero-filled and aligned to the top of the 24-bit word.
    typedef struct packed {
        logic        is_dec;    // decoded bytes rather than characters
        logic        no_data;   // closing marker only
        logic        last;      // final result of this job closes the message
        logic [1:0]  num_res;   // results in this job, minus one
        logic [1:0]  num_chars; // encode: data characters minus one, rest padded
        logic [23:0] full;      // aligned group bits
    } job_t;

    // Six-bit value to its base64 character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
                enc_char = CHAR_UPPER + w;
            else if (v < 6'd52)
                enc_char = CHAR_LOWER + (w - 8'd26);
            else if (v < 6'd62)
                enc_char = CHAR_DIGIT + (w - 8'd52);
            else if (v == 6'd62)
                enc_char = CHAR_PLUS;
            else
                enc_char = CHAR_SLASH;
        end
    endfunction

    // Character to its six-bit value; anything outside the alphabet is zero.
    function automatic logic [5:0] dec_six(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CHAR_UPPER && c <= 8'h5A)
                t = c - CHAR_UPPER;
            else if (c >= CHAR_LOWER && c <= 8'h7A)
                t = c - CHAR_LOWER + 8'd26;
            else if (c >= CHAR_DIGIT && c <= 8'h39)
                t = c - CHAR_DIGIT + 8'd52;
            else if (c == CHAR_PLUS)
                t = 8'd62;
            else if (c == CHAR_SLASH)
                t = 8'd63;
            dec_six = t[5:0];
        end
    endfunction

endpackage

>>> rtl/b64c_front.sv
// Front end of the base64 stream codec: holds the direction and the group
// being gathered, and emits one job per completed or flushed group. Uses b64c_pkg.
module b64c_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_data,
    input  logic           accept,
    input  logic [7:0]     data_in,
    input  logic           last_in,
    output logic           job_push,
    output b64c_pkg::job_t job
);

    logic        direction_reg;
    logic [23:0] group_bits_reg;
    logic [23:0] group_bits_next;
    logic [1:0]  group_count_reg;
    logic [1:0]  group_count_next;
    logic        job_made;
    logic [23:0] shifted;
    logic [2:0]  count_inc;

    always_comb
    begin
        job              = '0;
        job_made         = 1'b0;
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        shifted          = group_bits_reg;
        count_inc        = {1'b0, group_count_reg};

        if (direction_reg == b64c_pkg::DIR_ENCODE)
        begin
            shifted   = {group_bits_reg[15:0], data_in};
            count_inc = {1'b0, group_count_reg} + 3'd1;
            if (count_inc == 3'd3 || last_in)
            begin
                job_made      = 1'b1;
                job.is_dec    = 1'b0;
                job.last      = last_in;
                job.num_res   = 2'd3;
                job.num_chars = count_inc[1:0];
                case (count_inc)
                    3'd1:    job.full = {shifted[7:0], 16'd0};
                    3'd2:    job.full = {shifted[15:0], 8'd0};
                    default: job.full = shifted;
                endcase
                group_bits_next  = 24'd0;
                group_count_next = 2'd0;
            end
            else
            begin
                group_bits_next  = shifted;
                group_count_next = count_inc[1:0];
            end
        end
        else
        begin
            // The pad character adds nothing to the group.
            if (data_in != b64c_pkg::CHAR_PAD)
            begin
                shifted   = {group_bits_reg[17:0], b64c_pkg::dec_six(data_in)};
                count_inc = {1'b0, group_count_reg} + 3'd1;
            end
            if (count_inc == 3'd4)
            begin
                job_made    = 1'b1;
                job.is_dec  = 1'b1;
                job.last    = last_in;
                job.num_res = 2'd2;
                job.full    = shifted;
                group_bits_next  = 24'd0;
                group_count_next = 2'd0;
            end
            else if (last_in)
            begin
                job_made   = 1'b1;
                job.is_dec = 1'b1;
                job.last   = 1'b1;
                case (count_inc)
                    3'd0:
                    begin
                        job.no_data = 1'b1;
                        job.num_res = 2'd0;
                        job.full    = 24'd0;
                    end
                    3'd1:
                    begin
                        job.num_res = 2'd0;
                        job.full    = {shifted[5:0], 18'd0};
                    end
                    3'd2:
                    begin
                        job.num_res = 2'd0;
                        job.full    = {shifted[11:0], 12'd0};
                    end
                    default:
                    begin
                        job.num_res = 2'd1;
                        job.full    = {shifted[17:0], 6'd0};
                    end
                endcase
                group_bits_next  = 24'd0;
                group_count_next = 2'd0;
            end
            else
            begin
                group_bits_next  = shifted;
                group_count_next = count_inc[1:0];
            end
        end
    end

    assign job_push = accept && job_made;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= b64c_pkg::DIR_ENCODE;
            group_bits_reg  <= 24'd0;
            group_count_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            direction_reg   <= cfg_data;
            group_bits_reg  <= 24'd0;
            group_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule

>>> rtl/b64c_jobq.sv
// Small queue of group jobs between the front and back ends of the codec.
// Uses b64c_pkg for the job record.
module b64c_jobq
#(
    parameter int DEPTH = b64c_pkg::JOB_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  b64c_pkg::job_t wr_job,
    input  logic           rd_en,
    output b64c_pkg::job_t rd_job,
    output logic           q_full,
    output logic           q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64c_pkg::job_t   entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/b64c_back.sv
// Back end of the base64 stream codec: walks the head job one result per cycle,
// into the output register while free or popped; job and alphabet from b64c_pkg.
module b64c_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_avail,
    input  b64c_pkg::job_t job,
    output logic           job_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     data_out,
    output logic           no_data,
    output logic           last_out
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] data_reg;
    logic       no_data_reg;
    logic       last_reg;
    logic [1:0] idx_reg;
    logic       fire;
    logic       final_res;
    logic [7:0] res_data;
    logic [5:0] six;

    assign fire      = job_avail && (!out_valid_reg || pop);
    assign final_res = (idx_reg == job.num_res);
    assign job_pop   = fire && final_res;

    always_comb
    begin
        case (idx_reg)
            2'd0:    six = job.full[23:18];
            2'd1:    six = job.full[17:12];
            2'd2:    six = job.full[11:6];
            default: six = job.full[5:0];
        endcase

        if (job.is_dec)
        begin
            case (idx_reg)
                2'd0:    res_data = job.full[23:16];
                2'd1:    res_data = job.full[15:8];
                default: res_data = job.full[7:0];
            endcase
        end
        else if (idx_reg > job.num_chars)
            res_data = b64c_pkg::CHAR_PAD;
        else
            res_data = b64c_pkg::enc_char(six);
    end

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
                idx_reg <= final_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg    <= res_data;
            no_data_reg <= job.no_data;
            last_reg    <= job.last && final_res;
        end
    end

    assign empty    = !out_valid_reg;
    assign data_out = data_reg;
    assign no_data  = no_data_reg;
    assign last_out = last_reg;

endmodule

>>> rtl/base64_stream_codec_unit.sv
// Top level of the streaming base64 codec over the standard alphabet.
// Instantiates b64c_front, b64c_jobq and b64c_back; uses b64c_pkg.

// The codec takes one word per accepted push and gives results that are
// popped one word at a time. With cfg_data = 0 a write through cfg_we puts
// it in encode mode (bytes in, characters out); with cfg_data = 1 it
// decodes characters into bytes. Every configuration write also discards a
// partly gathered group, so it should only be done between messages while
// the block is idle. The front end gathers input words into a 24-bit group
// and, when a group completes or last_in flushes it, hands a job to a short
// queue; the back end turns the head job into its results at one result
// per clock cycle through a single output register, while it is free or
// popped, which is what sets the sustained rate: an encode stream of three
// bytes yields four characters, so encode input is bound by the output,
// while decode runs at one character per cycle when results are popped as
// they appear. Input is accepted every cycle while the job queue has room,
// also while a result waits to be popped. The first result of a group
// passes the job queue and then the output register. A message's final
// result carries last_out; a decode message that ends with nothing left to
// flush gives one closing word with no_data set and data_out zero.
module base64_stream_codec_unit
#(
    parameter int JOB_DEPTH = b64c_pkg::JOB_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_in,
    input  logic       last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_out,
    output logic       no_data,
    output logic       last_out
);

    logic           accept;
    logic           job_push;
    b64c_pkg::job_t job_in;
    b64c_pkg::job_t job_head;
    logic           job_pop;
    logic           q_full;
    logic           q_empty;

    // The front end stalls only when the job queue has no free entry.
    assign full   = q_full;
    assign accept = push && !q_full;

    b64c_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .data_in  (data_in),
        .last_in  (last_in),
        .job_push (job_push),
        .job      (job_in)
    );

    b64c_jobq #(.DEPTH(JOB_DEPTH)) u_jobq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .rd_en   (job_pop),
        .rd_job  (job_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back end works on the head job and pops it with its final result.
    b64c_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .data_out  (data_out),
        .no_data   (no_data),
        .last_out  (last_out)
    );

endmodule

>>> rtl/b64c_checker.sv
// Port-level checker for the base64 stream codec, bound to the top level.
// Uses the assertion macros of base64_stream_codec_unit_defines.svh.
`include "base64_stream_codec_unit_defines.svh"

module b64c_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] data_out,
    input logic       no_data,
    input logic       last_out
);

    // A closing marker always ends the message.
    `B64C_ASSERT_IMPLY(a_marker_is_last, clk, rst_n, !empty && no_data, last_out, "marker without last_out")

    // A closing marker carries no byte.
    `B64C_ASSERT_IMPLY(a_marker_zero, clk, rst_n, !empty && no_data, data_out == 8'd0, "marker with nonzero data")

    // A waiting result that is not popped stays in place unchanged.
    `B64C_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(data_out) && $stable(no_data) && $stable(last_out), "result changed while waiting")

endmodule

bind base64_stream_codec_unit b64c_checker u_b64c_checker (.*);
